FILE: hdl/rfp_pkg.sv
// Shared types, constants and helper functions of the RGB fade engine.
package rfp_pkg;

  localparam int unsigned RandW    = 16;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned ColorW   = 3 * LevelW;
  localparam int unsigned DelayW   = 10;
  localparam int unsigned SpeedW   = 8;
  localparam int unsigned JitW     = 5;
  localparam int unsigned DivisorW = 9;
  localparam int unsigned PalMax   = 16;
  localparam int unsigned PalIdxW  = 4;
  localparam int unsigned RandCntW = $clog2(RandW);
  localparam int unsigned DivCntW  = $clog2(DelayW);

  localparam logic [DelayW-1:0] DelayNum   = DelayW'(1000);
  localparam logic [JitW:0]     JitterMod  = (JitW + 1)'(25);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_CALC,
    ST_STEP
  } rfp_state_e;

  // Palette in index order; red in bits 7..0, green 15..8, blue 23..16.
  localparam logic [ColorW-1:0] Palette [PalMax] = '{
    24'hFFFFFF, 24'h0000FF, 24'h00FFFF, 24'h00FF00,
    24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'h000080,
    24'h008000, 24'h800000, 24'h008080, 24'h0080FF,
    24'h80FFFF, 24'h8000FF, 24'h000000, 24'h000000
  };

  function automatic logic [ColorW-1:0] rfp_color(input logic [PalIdxW-1:0] idx);
    return Palette[idx];
  endfunction

  // Move one channel one step toward its target.
  function automatic logic [LevelW-1:0] rfp_step_chan(input logic [LevelW-1:0] cur,
                                                      input logic [LevelW-1:0] tgt);
    logic [LevelW-1:0] res;
    res = cur;
    if (cur > tgt) begin
      res = cur - LevelW'(1);
    end else if (cur < tgt) begin
      res = cur + LevelW'(1);
    end
    return res;
  endfunction

endpackage

FILE: hdl/rfp_in_if.sv
// Input channel: tick or restart transaction with its random values.
interface rfp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [rfp_pkg::RandW-1:0]  rand_delay;
  logic [rfp_pkg::RandW-1:0]  rand_pick;

  modport source (output valid, action, rand_delay, rand_pick, input ready);
  modport sink   (input valid, action, rand_delay, rand_pick, output ready);
endinterface

FILE: hdl/rfp_out_if.sv
// Output channel: levels, dwell delay and new-target flag of one tick.
interface rfp_out_if;
  logic                        valid;
  logic                        ready;
  logic [rfp_pkg::LevelW-1:0]  red_level;
  logic [rfp_pkg::LevelW-1:0]  green_level;
  logic [rfp_pkg::LevelW-1:0]  blue_level;
  logic [rfp_pkg::DelayW-1:0]  dwell_delay;
  logic                        new_target;

  modport source (output valid, red_level, green_level, blue_level, dwell_delay, new_target,
                  input ready);
  modport sink   (input valid, red_level, green_level, blue_level, dwell_delay, new_target,
                  output ready);
endinterface

FILE: hdl/rgb_fade_random_palette_top.sv
// Fade engine for an RGB mood lamp. Each accepted tick transaction moves the
// red, green and blue levels one step toward the current target color and
// returns one result transaction with the new levels, the dwell delay and a
// flag that tells whether a new target was drawn. When the levels already sit
// on the target, the tick first computes a dwell delay of
// 1000 / (speed + rand_delay % 25 + 1) and draws a new target without
// replacement from a PALETTE_SIZE-entry palette: the (rand_pick % remaining)-th
// color still in the bag, in palette order; an empty bag refills first. A
// restart transaction zeroes the levels and empties the bag before the tick.
// A tick that draws no color goes straight to the step state, which loads
// its result into the output register. A tick that draws first reduces both
// 16-bit random values one bit per cycle, then runs the 10-bit serial
// divider beside the bag walk (one palette entry per cycle), then the step
// state. One transaction is in flight at a time; the next one is taken the
// cycle after the result is loaded, while that result may still wait in the
// output register. A stalled output holds the step cycle until the register
// frees. speed is written through speed_we_i/speed_i while the block is idle:
// the user must keep to this; the block itself does not enforce it.
module rgb_fade_random_palette_top #(
  parameter int unsigned PALETTE_SIZE = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        speed_we_i,
  input  logic [rfp_pkg::SpeedW-1:0]  speed_i,
  rfp_in_if.sink                      in_i,
  rfp_out_if.source                   out_o
);

  localparam int unsigned CntW = $clog2(PALETTE_SIZE + 1);
  localparam int unsigned IdxW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam logic [PALETTE_SIZE-1:0] FullMask = {PALETTE_SIZE{1'b1}};

  rfp_pkg::rfp_state_e state_q, state_d;

  logic [rfp_pkg::SpeedW-1:0]    speed_q;
  logic [rfp_pkg::ColorW-1:0]    level_q, target_q;
  logic [PALETTE_SIZE-1:0]       mask_q;
  logic [CntW-1:0]               count_q;
  logic [rfp_pkg::DelayW-1:0]    delay_q;
  logic                          draw_q;

  // Serial modulo datapath
  logic [rfp_pkg::RandW-1:0]     rd_sh_q, rp_sh_q;
  logic [rfp_pkg::RandCntW-1:0]  bit_cnt_q;
  logic [rfp_pkg::JitW-1:0]      jit_q, jit_d;
  logic [CntW-1:0]               pick_q, pick_d;
  logic [rfp_pkg::JitW:0]        jit_t;
  logic [CntW:0]                 pick_t;

  // Bag walk
  logic [IdxW-1:0]               idx_q;
  logic [CntW-1:0]               seen_q;
  logic                          walk_done_q;
  logic                          hit;

  // Output register
  logic                          out_valid_q;
  logic [rfp_pkg::LevelW-1:0]    red_q, green_q, blue_q;
  logic [rfp_pkg::DelayW-1:0]    out_delay_q;
  logic                          out_new_q;

  // Control decode
  logic                          in_fire, mod_last, calc_done, out_free, step_fire;
  logic                          lvl_hit;
  logic [rfp_pkg::DivisorW-1:0]  divisor;
  logic                          div_busy;
  logic [rfp_pkg::DelayW-1:0]    quotient;
  logic [rfp_pkg::ColorW-1:0]    level_next;

  rfp_div_serial u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_last),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfp_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = lvl_hit ? rfp_pkg::ST_MOD : rfp_pkg::ST_STEP;
        end
      end
      rfp_pkg::ST_MOD: begin
        if (mod_last) begin
          state_d = rfp_pkg::ST_CALC;
        end
      end
      rfp_pkg::ST_CALC: begin
        if (calc_done) begin
          state_d = rfp_pkg::ST_STEP;
        end
      end
      rfp_pkg::ST_STEP: begin
        if (out_free) begin
          state_d = rfp_pkg::ST_IDLE;
        end
      end
      default: state_d = rfp_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_i.ready = 1'b0;
    mod_last   = 1'b0;
    calc_done  = 1'b0;
    step_fire  = 1'b0;
    unique case (state_q)
      rfp_pkg::ST_IDLE: in_i.ready = 1'b1;
      rfp_pkg::ST_MOD:  mod_last   = (bit_cnt_q == rfp_pkg::RandCntW'(rfp_pkg::RandW - 1));
      rfp_pkg::ST_CALC: calc_done  = walk_done_q && !div_busy;
      rfp_pkg::ST_STEP: step_fire  = out_free;
      default: in_i.ready = 1'b0;
    endcase
  end

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // A restart zeroes the levels before the compare.
  assign lvl_hit = in_i.action ? (target_q == '0) : (level_q == target_q);

  // Reduce both random values one bit per cycle, MSB first.
  assign jit_t  = {jit_q, rd_sh_q[rfp_pkg::RandW-1]};
  assign pick_t = {pick_q, rp_sh_q[rfp_pkg::RandW-1]};

  always_comb begin
    jit_d  = jit_t[rfp_pkg::JitW-1:0];
    pick_d = pick_t[CntW-1:0];
    if (jit_t >= rfp_pkg::JitterMod) begin
      jit_d = rfp_pkg::JitW'(jit_t - rfp_pkg::JitterMod);
    end
    if (pick_t >= {1'b0, count_q}) begin
      pick_d = CntW'(pick_t - {1'b0, count_q});
    end
  end

  assign divisor = rfp_pkg::DivisorW'(speed_q) + rfp_pkg::DivisorW'(jit_d)
                 + rfp_pkg::DivisorW'(1);

  assign hit = mask_q[idx_q] && (seen_q == pick_q);

  assign level_next = {
    rfp_pkg::rfp_step_chan(level_q[23:16], target_q[23:16]),
    rfp_pkg::rfp_step_chan(level_q[15:8],  target_q[15:8]),
    rfp_pkg::rfp_step_chan(level_q[7:0],   target_q[7:0])
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rfp_pkg::ST_IDLE;
      speed_q     <= '0;
      level_q     <= '0;
      target_q    <= '0;
      mask_q      <= '0;
      count_q     <= '0;
      delay_q     <= rfp_pkg::DelayNum;
      draw_q      <= 1'b0;
      bit_cnt_q   <= '0;
      idx_q       <= '0;
      seen_q      <= '0;
      walk_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (speed_we_i) begin
        speed_q <= speed_i;
      end

      if (in_fire) begin
        draw_q    <= lvl_hit;
        bit_cnt_q <= '0;
        if (in_i.action) begin
          level_q <= '0;
        end
        // Refill an empty (or just emptied) bag only when a draw follows.
        if (lvl_hit && (in_i.action || count_q == '0)) begin
          mask_q  <= FullMask;
          count_q <= CntW'(PALETTE_SIZE);
        end else if (in_i.action) begin
          mask_q  <= '0;
          count_q <= '0;
        end
      end

      if (state_q == rfp_pkg::ST_MOD) begin
        bit_cnt_q <= bit_cnt_q + rfp_pkg::RandCntW'(1);
      end

      if (mod_last) begin
        idx_q       <= '0;
        seen_q      <= '0;
        walk_done_q <= 1'b0;
      end else if (state_q == rfp_pkg::ST_CALC && !walk_done_q) begin
        if (hit) begin
          walk_done_q   <= 1'b1;
          target_q      <= rfp_pkg::rfp_color(rfp_pkg::PalIdxW'(idx_q));
          mask_q[idx_q] <= 1'b0;
          count_q       <= count_q - CntW'(1);
        end else begin
          if (mask_q[idx_q]) begin
            seen_q <= seen_q + CntW'(1);
          end
          idx_q <= idx_q + IdxW'(1);
        end
      end

      if (calc_done) begin
        delay_q <= quotient;
      end

      if (step_fire) begin
        level_q     <= level_next;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_sh_q <= in_i.rand_delay;
      rp_sh_q <= in_i.rand_pick;
      jit_q   <= '0;
      pick_q  <= '0;
    end else if (state_q == rfp_pkg::ST_MOD) begin
      rd_sh_q <= {rd_sh_q[rfp_pkg::RandW-2:0], 1'b0};
      rp_sh_q <= {rp_sh_q[rfp_pkg::RandW-2:0], 1'b0};
      jit_q   <= jit_d;
      pick_q  <= pick_d;
    end
    if (step_fire) begin
      red_q       <= level_next[7:0];
      green_q     <= level_next[15:8];
      blue_q      <= level_next[23:16];
      out_delay_q <= delay_q;
      out_new_q   <= draw_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.red_level   = red_q;
  assign out_o.green_level = green_q;
  assign out_o.blue_level  = blue_q;
  assign out_o.dwell_delay = out_delay_q;
  assign out_o.new_target  = out_new_q;

endmodule

FILE: hdl/rfp_div_serial.sv
// Bit-serial restoring divider: constant 1000 divided by a 9-bit divisor.
module rfp_div_serial (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rfp_pkg::DivisorW-1:0]  divisor_i,
  output logic                          busy_o,
  output logic [rfp_pkg::DelayW-1:0]    quotient_o
);

  logic                          busy_q, busy_d;
  logic [rfp_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [rfp_pkg::DelayW-1:0]    dq_q, dq_d;
  logic [rfp_pkg::DivisorW-1:0]  rem_q, rem_d;
  logic [rfp_pkg::DivisorW-1:0]  dv_q, dv_d;
  logic [rfp_pkg::DivisorW:0]    trial;
  logic [rfp_pkg::DivisorW:0]    diff;
  logic                          ge;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {rem_q, dq_q[rfp_pkg::DelayW-1]};
  assign ge    = trial >= {1'b0, dv_q};
  assign diff  = trial - {1'b0, dv_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = rfp_pkg::DelayNum;
      rem_d  = '0;
      dv_d   = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[rfp_pkg::DivisorW-1:0] : trial[rfp_pkg::DivisorW-1:0];
      dq_d  = {dq_q[rfp_pkg::DelayW-2:0], ge};
      cnt_d = cnt_q + rfp_pkg::DivCntW'(1);
      if (cnt_q == rfp_pkg::DivCntW'(rfp_pkg::DelayW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = dq_q;

endmodule

FILE: tb/sv/rgb_fade_random_palette_top_tb.sv
// Self-checking testbench of the RGB fade engine: directed table, then random fade runs.
module rgb_fade_random_palette_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Action codes of the input transaction.
  localparam logic ActTick    = 1'b0;
  localparam logic ActRestart = 1'b1;

  localparam int unsigned ColorCount   = 14;
  localparam logic [13:0] BagFull      = 14'h3FFF;
  localparam int unsigned PhaseItems   = 300;
  localparam int unsigned PhaseCount   = 6;
  localparam int unsigned HoldOffLen   = 400;
  localparam int unsigned TailCycles   = 40;

  // Lamp colors in palette index order; red in bits 7..0, green 15..8, blue 23..16.
  localparam logic [rfp_pkg::ColorW-1:0] LampColors [ColorCount] = '{
    24'hFFFFFF, 24'h0000FF, 24'h00FFFF, 24'h00FF00,
    24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'h000080,
    24'h008000, 24'h800000, 24'h008080, 24'h0080FF,
    24'h80FFFF, 24'h8000FF
  };

  typedef struct packed {
    logic [rfp_pkg::LevelW-1:0] red;
    logic [rfp_pkg::LevelW-1:0] green;
    logic [rfp_pkg::LevelW-1:0] blue;
    logic [rfp_pkg::DelayW-1:0] dwell;
    logic                       drew;
  } fade_res_t;

  // One directed row; known rows carry their result typed in by hand.
  typedef struct packed {
    logic                      act;
    logic [rfp_pkg::RandW-1:0] rand_delay;
    logic [rfp_pkg::RandW-1:0] rand_pick;
    logic                      known;
    fade_res_t                 res;
  } fade_row_t;

  localparam int unsigned DirRows = 14;
  localparam fade_row_t FadeTable [DirRows] = '{
    // First tick after reset: levels sit on the black target, so white is drawn
    // (pick 0 of a full bag) with delay 1000 / (0 + 0 + 1).
    '{ActTick,    16'h0000, 16'h0000, 1'b1, '{8'd1, 8'd1, 8'd1, 10'd1000, 1'b1}},
    // Still fading toward white: no draw, delay unchanged.
    '{ActTick,    16'hFFFF, 16'hFFFF, 1'b1, '{8'd2, 8'd2, 8'd2, 10'd1000, 1'b0}},
    // Restart zeroes the levels; the target stays white, so no draw.
    '{ActRestart, 16'h0000, 16'h0000, 1'b1, '{8'd1, 8'd1, 8'd1, 10'd1000, 1'b0}},
    '{ActRestart, 16'hFFFF, 16'hFFFF, 1'b1, '{8'd1, 8'd1, 8'd1, 10'd1000, 1'b0}},
    '{ActTick,    16'hAAAA, 16'h5555, 1'b0, '0},
    '{ActTick,    16'h5555, 16'hAAAA, 1'b0, '0},
    '{ActTick,    16'h0018, 16'h000D, 1'b0, '0},
    '{ActRestart, 16'h0019, 16'h0001, 1'b0, '0},
    '{ActTick,    16'h8000, 16'h8000, 1'b0, '0},
    '{ActTick,    16'h7FFF, 16'h7FFF, 1'b0, '0},
    '{ActTick,    16'h0001, 16'hFFFE, 1'b0, '0},
    '{ActTick,    16'hFFFE, 16'h0001, 1'b0, '0},
    '{ActRestart, 16'hF0F0, 16'h0F0F, 1'b0, '0},
    '{ActTick,    16'h0F0F, 16'hF0F0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic speed_we;
  logic [rfp_pkg::SpeedW-1:0] speed_wdata;

  rfp_in_if  in_if ();
  rfp_out_if out_if ();

  rgb_fade_random_palette_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .speed_we_i (speed_we),
    .speed_i    (speed_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #2ns clk = ~clk;

  // Shadow of the lamp state, advanced once per accepted input transaction.
  logic [rfp_pkg::ColorW-1:0] lamp_level;
  logic [rfp_pkg::ColorW-1:0] lamp_target;
  logic [13:0]                lamp_bag;
  logic [rfp_pkg::DelayW-1:0] lamp_dwell;
  logic [rfp_pkg::SpeedW-1:0] lamp_speed;

  fade_res_t level_q [$];
  int unsigned fail_cnt = 0;

  // Sender pacing; hold-off requests are counted up by the sender only.
  int unsigned burst_left   = 0;
  int unsigned gap_due      = 0;
  bit          no_gap       = 1'b0;
  int unsigned holdoff_asks = 0;

  function automatic logic [rfp_pkg::LevelW-1:0] step_toward(
      input logic [rfp_pkg::LevelW-1:0] cur, input logic [rfp_pkg::LevelW-1:0] tgt);
    if (cur > tgt) return cur - 8'd1;
    if (cur < tgt) return cur + 8'd1;
    return cur;
  endfunction

  function automatic int unsigned bag_count();
    return (lamp_bag == '0) ? ColorCount : $countones(lamp_bag);
  endfunction

  // Take the (pick % remaining)-th color still in the bag; refill an empty bag first.
  function automatic logic [rfp_pkg::ColorW-1:0] pick_from_bag(
      input logic [rfp_pkg::RandW-1:0] pick);
    int unsigned left;
    int unsigned k;
    int unsigned seen;
    if (lamp_bag == '0) lamp_bag = BagFull;
    left = $countones(lamp_bag);
    k    = pick % left;
    seen = 0;
    for (int i = 0; i < ColorCount; i++) begin
      if (lamp_bag[i]) begin
        if (seen == k) begin
          lamp_bag[i] = 1'b0;
          return LampColors[i];
        end
        seen++;
      end
    end
    return '0;
  endfunction

  // Advance the lamp by one transaction and return the levels it shows afterwards.
  task automatic fade_tick(input logic act, input logic [rfp_pkg::RandW-1:0] rdelay,
                           input logic [rfp_pkg::RandW-1:0] rpick, output fade_res_t res);
    int unsigned div;
    res.drew = 1'b0;
    if (act == ActRestart) begin
      lamp_level = '0;
      lamp_bag   = '0;
    end
    if (lamp_level == lamp_target) begin
      div         = int'(lamp_speed) + (rdelay % 25) + 1;
      lamp_dwell  = rfp_pkg::DelayW'(1000 / div);
      lamp_target = pick_from_bag(rpick);
      res.drew    = 1'b1;
    end
    res.red   = step_toward(lamp_level[7:0],   lamp_target[7:0]);
    res.green = step_toward(lamp_level[15:8],  lamp_target[15:8]);
    res.blue  = step_toward(lamp_level[23:16], lamp_target[23:16]);
    lamp_level = {res.blue, res.green, res.red};
    res.dwell  = lamp_dwell;
  endtask

  // Offer one transaction and hold it until the handshake; pace bursts and gaps.
  task automatic send_fade(input logic act, input logic [rfp_pkg::RandW-1:0] rdelay,
                           input logic [rfp_pkg::RandW-1:0] rpick, input logic known,
                           input fade_res_t typed);
    fade_res_t res;
    if (gap_due != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap_due) @(posedge clk);
      gap_due = 0;
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.rand_delay <= rdelay;
    in_if.rand_pick  <= rpick;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    fade_tick(act, rdelay, rpick, res);
    level_q.insert(level_q.size(), known ? typed : res);
    if (!no_gap) begin
      if (burst_left != 0) burst_left--;
      if (burst_left == 0) begin
        gap_due    = $urandom_range(1, 24);
        // Mostly short bursts; now and then a long stretch with no gap at all.
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
      end
    end
  endtask

  // Drop valid, drain every outstanding result, then write speed while idle.
  task automatic write_speed(input logic [rfp_pkg::SpeedW-1:0] value);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (level_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    speed_we    <= 1'b1;
    speed_wdata <= value;
    @(posedge clk);
    speed_we    <= 1'b0;
    lamp_speed  = value;
  endtask

  function automatic void check_field(input string name,
                                      input logic [rfp_pkg::DelayW-1:0] want,
                                      input logic [rfp_pkg::DelayW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Receiver: switch between stall patterns; honor one long hold-off on request.
  initial begin : rx_pacing
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned rx_cycle;
    int unsigned holdoff_seen;
    mode         = 0;
    mode_left    = 0;
    hold_left    = 0;
    rx_cycle     = 0;
    holdoff_seen = 0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (holdoff_asks != holdoff_seen) begin
        // Hold off long enough for the block to fill and stall its input.
        holdoff_seen = holdoff_asks;
        hold_left    = HoldOffLen;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 256);
        end
        mode_left--;
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ~rx_cycle[1];
        endcase
      end
      @(posedge clk);
    end
  end

  // Compare each result transaction with the oldest pending one.
  always @(posedge clk) begin : result_check
    fade_res_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (level_q.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", out_if.red_level,
               out_if.green_level, out_if.blue_level);
        fail_cnt++;
      end else begin
        want = level_q.pop_front();
        check_field("red_level",   rfp_pkg::DelayW'(want.red),
                    rfp_pkg::DelayW'(out_if.red_level));
        check_field("green_level", rfp_pkg::DelayW'(want.green),
                    rfp_pkg::DelayW'(out_if.green_level));
        check_field("blue_level",  rfp_pkg::DelayW'(want.blue),
                    rfp_pkg::DelayW'(out_if.blue_level));
        check_field("dwell_delay", want.dwell, out_if.dwell_delay);
        check_field("new_target",  rfp_pkg::DelayW'(want.drew),
                    rfp_pkg::DelayW'(out_if.new_target));
      end
    end
  end

  initial begin : stimulus
    logic [rfp_pkg::SpeedW-1:0] phase_speed [PhaseCount];
    logic                       act;
    logic [rfp_pkg::RandW-1:0]  rdelay;
    logic [rfp_pkg::RandW-1:0]  rpick;
    int unsigned                left;

    rst_n            <= 1'b0;
    speed_we         <= 1'b0;
    speed_wdata      <= '0;
    in_if.valid      <= 1'b0;
    in_if.action     <= ActTick;
    in_if.rand_delay <= '0;
    in_if.rand_pick  <= '0;

    lamp_level  = '0;
    lamp_target = '0;
    lamp_bag    = '0;
    lamp_dwell  = rfp_pkg::DelayW'(1000);
    lamp_speed  = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at speed 0: field extremes, both actions, restart behavior.
    write_speed('0);
    for (int i = 0; i < DirRows; i++) begin
      send_fade(FadeTable[i].act, FadeTable[i].rand_delay, FadeTable[i].rand_pick,
                FadeTable[i].known, FadeTable[i].res);
    end

    // Random fade runs, one speed per phase, extremes included.
    phase_speed = '{8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd0,
                    8'($urandom_range(2, 254)), 8'd128};
    for (int ph = 0; ph < PhaseCount; ph++) begin
      write_speed(phase_speed[ph]);
      // Phase 1 keeps the sender busy against a long receiver hold-off.
      no_gap = (ph == 1);
      if (ph == 1) begin
        gap_due = 0;
        holdoff_asks++;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        // Mostly plain ticks so fades run to completion and draw new colors.
        act = ($urandom_range(0, 149) == 0) ? ActRestart : ActTick;
        case ($urandom_range(0, 3))
          0:       rdelay = 16'($urandom_range(0, 65535));
          1:       rdelay = 16'(25 * $urandom_range(0, 2620));
          2:       rdelay = 16'(25 * $urandom_range(0, 2620) + 24);
          default: rdelay = 16'($urandom_range(0, 24));
        endcase
        // Aim some picks at the first and the last color left in the bag.
        left = bag_count();
        case ($urandom_range(0, 3))
          0, 1:    rpick = 16'($urandom_range(0, 65535));
          2:       rpick = 16'(left * $urandom_range(0, 65535 / left - 1) + left - 1);
          default: rpick = 16'(left * $urandom_range(0, 65535 / left - 1));
        endcase
        send_fade(act, rdelay, rpick, 1'b0, '0);
      end
    end

    // Drain, then keep watching the output for anything stray before the verdict.
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (level_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #3ms;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: rgb_fade_random_palette_top.f
hdl/rfp_pkg.sv
hdl/rfp_in_if.sv
hdl/rfp_out_if.sv
hdl/rfp_div_serial.sv
hdl/rgb_fade_random_palette_top.sv
tb/sv/rgb_fade_random_palette_top_tb.sv
